/* rtl/limit_order_book_matcher_top_assert.svh */
// Assertion macros for the order book matcher checker
`ifndef LIMIT_ORDER_BOOK_MATCHER_TOP_ASSERT_SVH
`define LIMIT_ORDER_BOOK_MATCHER_TOP_ASSERT_SVH

// Antecedent in this cycle implies consequent in this cycle
`define LOBM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: label");

// Antecedent in this cycle implies consequent in the next cycle
`define LOBM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: label");

`endif

/* rtl/lobm_pkg.sv */
package lobm_pkg;

    localparam int BOOK_DEPTH   = 64;
    localparam int PRICE_WIDTH  = 32;
    localparam int VOLUME_WIDTH = 32;
    localparam int ADDR_W       = $clog2(BOOK_DEPTH);
    localparam int CNT_W        = $clog2(BOOK_DEPTH + 1);

    localparam logic [1:0] REQ_BUY    = 2'd0;
    localparam logic [1:0] REQ_SELL   = 2'd1;

    localparam logic [1:0] ST_RESTED  = 2'd0;
    localparam logic [1:0] ST_FILLED  = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_DROPPED = 2'd3;

    typedef struct packed {
        logic [1:0]              req_type;
        logic [PRICE_WIDTH-1:0]  order_price;
        logic [VOLUME_WIDTH-1:0] order_volume;
    } order_t;

    typedef struct packed {
        logic [1:0]              status;
        logic [VOLUME_WIDTH-1:0] remaining_volume;
        logic [PRICE_WIDTH-1:0]  best_bid;
        logic [PRICE_WIDTH-1:0]  best_ask;
        logic [PRICE_WIDTH-1:0]  last_deal_price;
    } result_t;

    typedef struct packed {
        logic [PRICE_WIDTH-1:0]  price;
        logic [VOLUME_WIDTH-1:0] volume;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OPP_RD,
        S_OPP_CMP,
        S_POST,
        S_INS_RD,
        S_INS_CMP,
        S_HEAD_RD,
        S_EMIT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_OPP_RD,
        OP_TAKE_FULL,
        OP_TAKE_PART,
        OP_FILLED,
        OP_DROP,
        OP_INS_START,
        OP_INS_RD,
        OP_INS_SHIFT,
        OP_INS_PLACE,
        OP_HEAD_RD,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic invalid;
        logic vol_zero;
        logic opp_empty;
        logic match;
        logic vol_ge;
        logic own_full;
        logic pos_zero;
        logic shift_ok;
    } dp_stat_t;

    // Map a position within a book to its circular-buffer address
    function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] head,
                                                    input logic [CNT_W-1:0]  idx);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(head) + (CNT_W+1)'(idx);
        if (sum >= (CNT_W+1)'(BOOK_DEPTH))
        begin
            sum = sum - (CNT_W+1)'(BOOK_DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] head_inc(input logic [ADDR_W-1:0] head);
        return (head == ADDR_W'(BOOK_DEPTH - 1)) ? '0 : head + ADDR_W'(1);
    endfunction

endpackage

/* rtl/lobm_datapath.sv */
module lobm_datapath
    import lobm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  dp_cmd_t  cmd,
    input  order_t   order,
    output dp_stat_t stat,
    output result_t  result,
    output logic     done
);

    entry_t bid_mem [BOOK_DEPTH];
    entry_t ask_mem [BOOK_DEPTH];
    entry_t bid_rdata_reg;
    entry_t ask_rdata_reg;

    logic [CNT_W-1:0]        bid_cnt_reg;
    logic [CNT_W-1:0]        ask_cnt_reg;
    logic [ADDR_W-1:0]       bid_head_reg;
    logic [ADDR_W-1:0]       ask_head_reg;
    logic [PRICE_WIDTH-1:0]  last_reg;
    logic                    done_reg;

    logic                    side_buy_reg;
    logic                    invalid_reg;
    logic [PRICE_WIDTH-1:0]  price_reg;
    logic [VOLUME_WIDTH-1:0] vol_reg;
    logic [1:0]              status_reg;
    logic [CNT_W-1:0]        pos_reg;
    result_t                 result_reg;

    logic [CNT_W-1:0]  opp_cnt;
    logic [CNT_W-1:0]  own_cnt;
    entry_t            opp_rdata;
    entry_t            own_rdata;
    entry_t            new_entry;
    entry_t            part_entry;
    logic              own_wr;
    logic [ADDR_W-1:0] bid_raddr;
    logic [ADDR_W-1:0] ask_raddr;
    logic              bid_we;
    logic              ask_we;
    logic [ADDR_W-1:0] bid_waddr;
    logic [ADDR_W-1:0] ask_waddr;
    entry_t            bid_wdata;
    entry_t            ask_wdata;

    // Select the opposite and own book by side
    assign opp_cnt   = side_buy_reg ? ask_cnt_reg : bid_cnt_reg;
    assign own_cnt   = side_buy_reg ? bid_cnt_reg : ask_cnt_reg;
    assign opp_rdata = side_buy_reg ? ask_rdata_reg : bid_rdata_reg;
    assign own_rdata = side_buy_reg ? bid_rdata_reg : ask_rdata_reg;
    assign new_entry  = '{price: price_reg, volume: vol_reg};
    assign part_entry = '{price: opp_rdata.price, volume: opp_rdata.volume - vol_reg};
    assign own_wr = (cmd.op == OP_INS_SHIFT) || (cmd.op == OP_INS_PLACE);

    // Read at the head, or one place above the insert slot while scanning
    always_comb
    begin
        bid_raddr = bid_head_reg;
        ask_raddr = ask_head_reg;
        if (cmd.op == OP_INS_RD)
        begin
            if (side_buy_reg)
            begin
                bid_raddr = phys_addr(bid_head_reg, pos_reg - CNT_W'(1));
            end
            else
            begin
                ask_raddr = phys_addr(ask_head_reg, pos_reg - CNT_W'(1));
            end
        end
    end

    // Steer writes: own book for shift and place, opposite head for a partial fill
    always_comb
    begin
        bid_we    = side_buy_reg ? own_wr : (cmd.op == OP_TAKE_PART);
        ask_we    = side_buy_reg ? (cmd.op == OP_TAKE_PART) : own_wr;
        bid_waddr = side_buy_reg ? phys_addr(bid_head_reg, pos_reg) : bid_head_reg;
        ask_waddr = side_buy_reg ? ask_head_reg : phys_addr(ask_head_reg, pos_reg);
        if (cmd.op == OP_TAKE_PART)
        begin
            bid_wdata = part_entry;
            ask_wdata = part_entry;
        end
        else if (cmd.op == OP_INS_SHIFT)
        begin
            bid_wdata = own_rdata;
            ask_wdata = own_rdata;
        end
        else
        begin
            bid_wdata = new_entry;
            ask_wdata = new_entry;
        end
    end

    // Book memories, one read and one write port each
    always_ff @(posedge clk)
    begin
        if (bid_we)
        begin
            bid_mem[bid_waddr] <= bid_wdata;
        end
        bid_rdata_reg <= bid_mem[bid_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ask_we)
        begin
            ask_mem[ask_waddr] <= ask_wdata;
        end
        ask_rdata_reg <= ask_mem[ask_raddr];
    end

    // Book counts, heads, last deal price and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bid_cnt_reg  <= '0;
            ask_cnt_reg  <= '0;
            bid_head_reg <= '0;
            ask_head_reg <= '0;
            last_reg     <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= (cmd.op == OP_EMIT);
            case (cmd.op)
                OP_TAKE_FULL:
                begin
                    last_reg <= opp_rdata.price;
                    if (side_buy_reg)
                    begin
                        ask_head_reg <= head_inc(ask_head_reg);
                        ask_cnt_reg  <= ask_cnt_reg - CNT_W'(1);
                    end
                    else
                    begin
                        bid_head_reg <= head_inc(bid_head_reg);
                        bid_cnt_reg  <= bid_cnt_reg - CNT_W'(1);
                    end
                end
                OP_FILLED:
                begin
                    last_reg <= price_reg;
                end
                OP_INS_PLACE:
                begin
                    if (side_buy_reg)
                    begin
                        bid_cnt_reg <= bid_cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ask_cnt_reg <= ask_cnt_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Order under work and the result word
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                side_buy_reg <= (order.req_type == REQ_BUY);
                invalid_reg  <= order.req_type[1];
                price_reg    <= order.order_price;
                vol_reg      <= order.order_volume;
                status_reg   <= ST_INVALID;
            end
            OP_TAKE_FULL: vol_reg    <= vol_reg - opp_rdata.volume;
            OP_TAKE_PART: vol_reg    <= '0;
            OP_FILLED:    status_reg <= ST_FILLED;
            OP_DROP:      status_reg <= ST_DROPPED;
            OP_INS_START:
            begin
                pos_reg    <= own_cnt;
                status_reg <= ST_RESTED;
            end
            OP_INS_SHIFT: pos_reg <= pos_reg - CNT_W'(1);
            OP_EMIT:
            begin
                result_reg.status           <= status_reg;
                result_reg.remaining_volume <= vol_reg;
                result_reg.best_bid         <= (bid_cnt_reg != '0) ? bid_rdata_reg.price : '0;
                result_reg.best_ask         <= (ask_cnt_reg != '0) ? ask_rdata_reg.price : '0;
                result_reg.last_deal_price  <= last_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Report conditions to the controller
    always_comb
    begin
        stat.invalid   = invalid_reg;
        stat.vol_zero  = (vol_reg == '0);
        stat.opp_empty = (opp_cnt == '0);
        stat.match     = side_buy_reg ? (opp_rdata.price <= price_reg)
                                      : (opp_rdata.price >= price_reg);
        stat.vol_ge    = (vol_reg >= opp_rdata.volume);
        stat.own_full  = (own_cnt == CNT_W'(BOOK_DEPTH));
        stat.pos_zero  = (pos_reg == '0);
        stat.shift_ok  = side_buy_reg ? (own_rdata.price <= price_reg)
                                      : (own_rdata.price >= price_reg);
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

/* rtl/lobm_ctrl.sv */
module lobm_ctrl
    import lobm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     busy
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_OPP_RD;
                end
            end
            S_OPP_RD:
            begin
                if (stat.invalid)
                begin
                    state_next = S_HEAD_RD;
                end
                else if (stat.vol_zero || stat.opp_empty)
                begin
                    state_next = S_POST;
                end
                else
                begin
                    state_next = S_OPP_CMP;
                end
            end
            S_OPP_CMP:
            begin
                state_next = (stat.match && stat.vol_ge) ? S_OPP_RD : S_POST;
            end
            S_POST:
            begin
                state_next = (stat.vol_zero || stat.own_full) ? S_HEAD_RD : S_INS_RD;
            end
            S_INS_RD:
            begin
                state_next = stat.pos_zero ? S_HEAD_RD : S_INS_CMP;
            end
            S_INS_CMP:
            begin
                state_next = stat.shift_ok ? S_INS_RD : S_HEAD_RD;
            end
            S_HEAD_RD: state_next = S_EMIT;
            S_EMIT:    state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Command decode
    always_comb
    begin
        cmd.op = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op = OP_LOAD;
                end
            end
            S_OPP_RD: cmd.op = OP_OPP_RD;
            S_OPP_CMP:
            begin
                if (!stat.match)
                begin
                    cmd.op = OP_NONE;
                end
                else if (stat.vol_ge)
                begin
                    cmd.op = OP_TAKE_FULL;
                end
                else
                begin
                    cmd.op = OP_TAKE_PART;
                end
            end
            S_POST:
            begin
                if (stat.vol_zero)
                begin
                    cmd.op = OP_FILLED;
                end
                else if (stat.own_full)
                begin
                    cmd.op = OP_DROP;
                end
                else
                begin
                    cmd.op = OP_INS_START;
                end
            end
            S_INS_RD:  cmd.op = stat.pos_zero ? OP_INS_PLACE : OP_INS_RD;
            S_INS_CMP: cmd.op = stat.shift_ok ? OP_INS_SHIFT : OP_INS_PLACE;
            S_HEAD_RD: cmd.op = OP_HEAD_RD;
            S_EMIT:    cmd.op = OP_EMIT;
            default:   cmd.op = OP_NONE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

/* rtl/limit_order_book_matcher_top.sv */
// An invalid request goes straight to the head read and the result; a valid one takes
// longer for each resting order filled in full and each entry shifted for the sorted
// insert.
// Throughput: one request at a time; set by the read-compare loop on the book memories.
// The receiver cannot stall: done pulses for one cycle with the result.
// Reset: asynchronous, active low; both books empty, last deal price zero.
module limit_order_book_matcher_top
    import lobm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  order_t  order,
    output result_t result,
    output logic    done
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    lobm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    lobm_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .order  (order),
        .stat   (stat),
        .result (result),
        .done   (done)
    );

endmodule

/* rtl/lobm_checker.sv */
`include "limit_order_book_matcher_top_assert.svh"

module lobm_checker
    import lobm_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input result_t result,
    input logic    done
);

    // A result strobe lasts one cycle
    `LOBM_ASSERT_NEXT(a_done_single, done, !done)
    // An accepted request makes the block busy
    `LOBM_ASSERT_NEXT(a_start_busy, start && !busy, busy)
    // Results appear only once the block is free again
    `LOBM_ASSERT_NOW(a_done_idle, done, !busy)
    // A filled order has nothing left over
    `LOBM_ASSERT_NOW(a_filled_zero, done && (result.status == ST_FILLED),
                     result.remaining_volume == '0)

endmodule

bind limit_order_book_matcher_top lobm_checker u_lobm_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .result (result),
    .done   (done)
);

/* sim/limit_order_book_matcher_top_tb.sv */
`timescale 1ns / 100ps

module limit_order_book_matcher_top_tb;
    import lobm_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 4 * BOOK_DEPTH + 16;
    localparam int RANDOM_ORDERS  = 400;
    localparam logic [1:0] REQ_BAD2 = 2'd2;
    localparam logic [1:0] REQ_BAD3 = 2'd3;

    typedef struct {
        order_t  ord;
        logic    has_exp;
        result_t exp;
    } dir_row_t;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    order_t  order;
    result_t result;
    logic    done;

    // Shadow books, best price at index 0
    logic [PRICE_WIDTH-1:0]  bid_px [$];
    logic [VOLUME_WIDTH-1:0] bid_qty [$];
    logic [PRICE_WIDTH-1:0]  ask_px [$];
    logic [VOLUME_WIDTH-1:0] ask_qty [$];
    logic [PRICE_WIDTH-1:0]  deal_px;

    result_t  pending_results [$];
    result_t  typed_results [$];
    logic     typed_valid [$];
    dir_row_t dir_rows [$];

    int mismatch_count;
    int result_count;
    int order_count;
    int fill_count;
    int drop_count;
    int idle_cycles;
    int send_idle_pct;
    logic timed_out;

    limit_order_book_matcher_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .order  (order),
        .result (result),
        .done   (done)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Match one order against the shadow books and return the expected result
    function automatic result_t match_order(input order_t o);
        result_t r;
        logic [VOLUME_WIDTH-1:0] qty;
        logic is_buy;
        int pos;
        qty = o.order_volume;
        if (o.req_type != REQ_BUY && o.req_type != REQ_SELL)
        begin
            r.status = ST_INVALID;
        end
        else
        begin
            is_buy = (o.req_type == REQ_BUY);
            if (is_buy)
            begin
                while (ask_px.size() > 0 && ask_px[0] <= o.order_price && qty != 0)
                begin
                    if (qty >= ask_qty[0])
                    begin
                        qty = qty - ask_qty[0];
                        deal_px = ask_px[0];
                        void'(ask_px.pop_front());
                        void'(ask_qty.pop_front());
                    end
                    else
                    begin
                        ask_qty[0] = ask_qty[0] - qty;
                        qty = '0;
                    end
                end
            end
            else
            begin
                while (bid_px.size() > 0 && bid_px[0] >= o.order_price && qty != 0)
                begin
                    if (qty >= bid_qty[0])
                    begin
                        qty = qty - bid_qty[0];
                        deal_px = bid_px[0];
                        void'(bid_px.pop_front());
                        void'(bid_qty.pop_front());
                    end
                    else
                    begin
                        bid_qty[0] = bid_qty[0] - qty;
                        qty = '0;
                    end
                end
            end
            if (qty == 0)
            begin
                deal_px = o.order_price;
                r.status = ST_FILLED;
            end
            else if (is_buy)
            begin
                if (bid_px.size() >= BOOK_DEPTH)
                begin
                    r.status = ST_DROPPED;
                end
                else
                begin
                    pos = 0;
                    while (pos < bid_px.size() && bid_px[pos] > o.order_price)
                    begin
                        pos++;
                    end
                    bid_px.insert(pos, o.order_price);
                    bid_qty.insert(pos, qty);
                    r.status = ST_RESTED;
                end
            end
            else
            begin
                if (ask_px.size() >= BOOK_DEPTH)
                begin
                    r.status = ST_DROPPED;
                end
                else
                begin
                    pos = 0;
                    while (pos < ask_px.size() && ask_px[pos] < o.order_price)
                    begin
                        pos++;
                    end
                    ask_px.insert(pos, o.order_price);
                    ask_qty.insert(pos, qty);
                    r.status = ST_RESTED;
                end
            end
        end
        r.remaining_volume = qty;
        r.best_bid = (bid_px.size() > 0) ? bid_px[0] : '0;
        r.best_ask = (ask_px.size() > 0) ? ask_px[0] : '0;
        r.last_deal_price = deal_px;
        return r;
    endfunction

    function automatic order_t make_order(input logic [1:0] side,
                                          input logic [PRICE_WIDTH-1:0] px,
                                          input logic [VOLUME_WIDTH-1:0] qty);
        order_t o;
        o.req_type = side;
        o.order_price = px;
        o.order_volume = qty;
        return o;
    endfunction

    function automatic result_t make_result(input logic [1:0] st,
                                            input logic [VOLUME_WIDTH-1:0] qty,
                                            input logic [PRICE_WIDTH-1:0] bb,
                                            input logic [PRICE_WIDTH-1:0] ba,
                                            input logic [PRICE_WIDTH-1:0] lp);
        result_t r;
        r.status = st;
        r.remaining_volume = qty;
        r.best_bid = bb;
        r.best_ask = ba;
        r.last_deal_price = lp;
        return r;
    endfunction

    // Random order: mostly a narrow price band so that books cross often
    function automatic order_t random_order(input int book_bias);
        order_t o;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
        begin
            o.req_type = $urandom_range(2, 3);
        end
        else if (pick < 4 + book_bias)
        begin
            o.req_type = REQ_BUY;
        end
        else
        begin
            o.req_type = REQ_SELL;
        end
        pick = $urandom_range(0, 99);
        if (pick < 80)
        begin
            o.order_price = 32'd1000 + $urandom_range(0, 40);
        end
        else
        begin
            o.order_price = $urandom();
        end
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            o.order_volume = '0;
        end
        else if (pick < 85)
        begin
            o.order_volume = $urandom_range(1, 200);
        end
        else
        begin
            o.order_volume = $urandom();
        end
        return o;
    endfunction

    // Present one request and hold it until accepted; start stays high afterwards
    task automatic send_order(input order_t o, input logic has_exp, input result_t exp);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        order <= o;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        pending_results.push_back(match_order(o));
        typed_valid.push_back(has_exp);
        typed_results.push_back(exp);
        order_count++;
    endtask

    // Drop start and wait until every expected result has come back
    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() > 0 && !timed_out)
        begin
            @(posedge clk);
        end
    endtask

    // Check each result against the oldest expectation
    always @(posedge clk)
    begin
        result_t exp;
        result_t typed;
        logic    has_typed;
        if (rst_n && done)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("unexpected result %h", result);
                end
            end
            else
            begin
                exp = pending_results.pop_front();
                typed = typed_results.pop_front();
                has_typed = typed_valid.pop_front();
                if (has_typed && typed != exp)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("table row disagrees: table %h predicted %h", typed, exp);
                    end
                end
                if (result.status == ST_FILLED)
                begin
                    fill_count++;
                end
                if (result.status == ST_DROPPED)
                begin
                    drop_count++;
                end
                if (result.status !== exp.status
                    || result.remaining_volume !== exp.remaining_volume
                    || result.best_bid !== exp.best_bid
                    || result.best_ask !== exp.best_ask
                    || result.last_deal_price !== exp.last_deal_price)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("result %0d: exp st=%0d rem=%0d bb=%0d ba=%0d lp=%0d",
                                 result_count, exp.status, exp.remaining_volume,
                                 exp.best_bid, exp.best_ask, exp.last_deal_price);
                        $display("result %0d: got st=%0d rem=%0d bb=%0d ba=%0d lp=%0d",
                                 result_count, result.status, result.remaining_volume,
                                 result.best_bid, result.best_ask, result.last_deal_price);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                timed_out = 1'b1;
                $display("limit_order_book_matcher_top: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        dir_row_t row;
        result_t none;
        int i;
        int phase;
        none = '0;
        rst_n = 1'b0;
        start = 1'b0;
        order = '0;
        deal_px = '0;
        mismatch_count = 0;
        result_count = 0;
        order_count = 0;
        fill_count = 0;
        drop_count = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        send_idle_pct = 0;

        // Directed table: typed results only where obvious
        dir_rows.push_back('{make_order(REQ_BAD2, 32'd5, 32'd7), 1'b1,
                             make_result(ST_INVALID, 32'd7, 0, 0, 0)});
        dir_rows.push_back('{make_order(REQ_BAD3, '1, '1), 1'b1,
                             make_result(ST_INVALID, '1, 0, 0, 0)});
        dir_rows.push_back('{make_order(REQ_BUY, 32'd9, 32'd0), 1'b1,
                             make_result(ST_FILLED, 0, 0, 0, 32'd9)});
        dir_rows.push_back('{make_order(REQ_BUY, 32'd100, 32'd10), 1'b1,
                             make_result(ST_RESTED, 32'd10, 32'd100, 0, 32'd9)});
        dir_rows.push_back('{make_order(REQ_BUY, '1, '1), 1'b0, none});
        dir_rows.push_back('{make_order(REQ_BUY, 32'd100, 32'd5), 1'b0, none});
        dir_rows.push_back('{make_order(REQ_SELL, 32'd0, 32'd1), 1'b0, none});
        dir_rows.push_back('{make_order(REQ_SELL, '1, 32'd3), 1'b0, none});
        dir_rows.push_back('{make_order(REQ_SELL, 32'd100, '1), 1'b0, none});
        dir_rows.push_back('{make_order(REQ_SELL, 32'd0, '1), 1'b0, none});
        dir_rows.push_back('{make_order(REQ_BUY, 32'd0, 32'd4), 1'b0, none});
        dir_rows.push_back('{make_order(REQ_BUY, '1, 32'd2), 1'b0, none});
        dir_rows.push_back('{make_order(REQ_SELL, 32'd50, 32'd0), 1'b0, none});
        dir_rows.push_back('{make_order(REQ_SELL, 32'd200, 32'd6), 1'b0, none});
        dir_rows.push_back('{make_order(REQ_SELL, 32'd200, 32'd8), 1'b0, none});
        dir_rows.push_back('{make_order(REQ_BUY, 32'd300, 32'd10), 1'b0, none});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            send_order(row.ord, row.has_exp, row.exp);
        end
        wait_drained();

        // Fill the ask book to overflow, then sweep it with one buy
        for (i = 0; i < BOOK_DEPTH + 3; i++)
        begin
            send_order(make_order(REQ_SELL, 32'h8000_0000 + $urandom_range(0, 20),
                                  $urandom_range(1, 5)), 1'b0, none);
        end
        send_order(make_order(REQ_BUY, '1, '1), 1'b0, none);
        // Fill the bid book to overflow, then sweep it with one sell
        for (i = 0; i < BOOK_DEPTH + 3; i++)
        begin
            send_order(make_order(REQ_BUY, $urandom_range(0, 20),
                                  $urandom_range(1, 5)), 1'b0, none);
        end
        send_order(make_order(REQ_SELL, 32'd0, '1), 1'b0, none);
        wait_drained();

        // Random phases: sender idling varies, bias moves books to fill and drain
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 26 : ((phase == 1) ? 48 : 0);
            for (i = 0; i < RANDOM_ORDERS / 3; i++)
            begin
                send_order(random_order((i % 120 < 60) ? 60 : 32), 1'b0, none);
            end
            // Hold off until everything has returned
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d orders, checked %0d results (%0d filled, %0d dropped).",
                 order_count, result_count, fill_count, drop_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
        begin
            $display("limit_order_book_matcher_top: match");
        end
        else
        begin
            $display("Mismatches: %0d, outstanding: %0d", mismatch_count,
                     pending_results.size());
            $display("limit_order_book_matcher_top: mismatch");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/lobm_pkg.sv
rtl/lobm_datapath.sv
rtl/lobm_ctrl.sv
rtl/limit_order_book_matcher_top.sv
rtl/lobm_checker.sv
sim/limit_order_book_matcher_top_tb.sv
